// ===== rtl/utf8_to_utf16_bmp_decoder_macros.svh =====
// Assertion macros for the UTF-8 to UTF-16 decoder.
`ifndef UTF8_TO_UTF16_BMP_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_BMP_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define U8U16_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8u16 assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define U8U16_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8u16 assertion failed");

`endif

// ===== rtl/u8u16_pkg.sv =====
// Types and constants shared by the UTF-8 to UTF-16 decoder.
`default_nettype none
package u8u16_pkg;

    localparam int BYTE_W = 8;
    localparam int UNIT_W = 16;
    localparam int ACC_W  = 31;
    localparam int REM_W  = 3;

    // Low payload bits of a continuation byte
    localparam logic [7:0] CONT_MASK = 8'h3F;

    // BMP window limits
    localparam logic [15:0] BMP_LOW_MAX   = 16'hD7FF;
    localparam logic [15:0] BMP_HIGH_MIN  = 16'hE000;

    // Lead byte prefix masks and patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] LEAD5_MASK = 8'hFC;
    localparam logic [7:0] LEAD5_PAT  = 8'hF8;
    localparam logic [7:0] LEAD6_MASK = 8'hFE;
    localparam logic [7:0] LEAD6_PAT  = 8'hFC;

    // Decoder state: continuation bytes still expected and bits gathered
    typedef struct packed {
        logic [REM_W-1:0] remaining;
        logic [ACC_W-1:0] acc;
    } dec_state_t;

    // One step's result toward the output register
    typedef struct packed {
        logic              emit;
        logic [UNIT_W-1:0] unit;
    } dec_result_t;

endpackage
`default_nettype wire

// ===== rtl/u8u16_byte_if.sv =====
// Byte channel: valid/ready handshake carrying one UTF-8 byte per beat.
`default_nettype none
interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;

    modport source (output valid, output byte_value, input ready);
    modport sink   (input valid, input byte_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/u8u16_unit_if.sv =====
// Unit channel: valid/ready handshake carrying one UTF-16 code unit per beat.
`default_nettype none
interface u8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] utf16_unit;

    modport source (output valid, output utf16_unit, input ready);
    modport sink   (input valid, input utf16_unit, output ready);
endinterface
`default_nettype wire

// ===== rtl/u8u16_step.sv =====
// Combinational decode of one UTF-8 byte against the current decoder state.
`default_nettype none
module u8u16_step (
    input  var u8u16_pkg::dec_state_t  state,
    input  var logic [7:0]             byte_value,
    output u8u16_pkg::dec_state_t      state_next,
    output u8u16_pkg::dec_result_t     result
);
    import u8u16_pkg::*;

    logic [ACC_W-1:0]  acc_shift;
    logic [REM_W-1:0]  rem_dec;
    logic [ACC_W-1:0]  cp;
    logic              cp_done;
    logic              in_bmp;

    // Continuation path: shift in six bits, count down
    assign acc_shift = {state.acc[ACC_W-7:0], 6'(byte_value & CONT_MASK)};
    assign rem_dec   = state.remaining - REM_W'(1);

    // BMP check: upper bits clear and not in the surrogate range
    always_comb
    begin
        in_bmp = (cp[ACC_W-1:UNIT_W] == '0) &&
                 ((cp[UNIT_W-1:0] <= BMP_LOW_MAX) || (cp[UNIT_W-1:0] >= BMP_HIGH_MIN));
    end

    always_comb
    begin
        state_next = state;
        cp         = '0;
        cp_done    = 1'b0;
        priority if (byte_value == 8'h00)
        begin
            // NUL abandons any open sequence
            state_next.remaining = '0;
            state_next.acc       = '0;
        end
        else if (state.remaining != '0)
        begin
            if (rem_dec == '0)
            begin
                cp                   = acc_shift;
                cp_done              = 1'b1;
                state_next.remaining = '0;
                state_next.acc       = '0;
            end
            else
            begin
                state_next.remaining = rem_dec;
                state_next.acc       = acc_shift;
            end
        end
        else if (byte_value[7] == 1'b0)
        begin
            // Plain ASCII
            cp      = ACC_W'(byte_value);
            cp_done = 1'b1;
        end
        else if ((byte_value & LEAD2_MASK) == LEAD2_PAT)
        begin
            state_next.remaining = REM_W'(1);
            state_next.acc       = ACC_W'(byte_value[4:0]);
        end
        else if ((byte_value & LEAD3_MASK) == LEAD3_PAT)
        begin
            state_next.remaining = REM_W'(2);
            state_next.acc       = ACC_W'(byte_value[3:0]);
        end
        else if ((byte_value & LEAD4_MASK) == LEAD4_PAT)
        begin
            state_next.remaining = REM_W'(3);
            state_next.acc       = ACC_W'(byte_value[2:0]);
        end
        else if ((byte_value & LEAD5_MASK) == LEAD5_PAT)
        begin
            state_next.remaining = REM_W'(4);
            state_next.acc       = ACC_W'(byte_value[1:0]);
        end
        else if ((byte_value & LEAD6_MASK) == LEAD6_PAT)
        begin
            state_next.remaining = REM_W'(5);
            state_next.acc       = ACC_W'(byte_value[0]);
        end
        else
        begin
            // Stray continuation or 0xFE/0xFF lead: skipped, state kept
            state_next = state;
        end
    end

    assign result.emit = cp_done && in_bmp;
    assign result.unit = cp[UNIT_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/utf8_to_utf16_bmp_decoder.sv =====
// Top level of the byte-serial UTF-8 to UTF-16 (BMP) decoder.
//
//  channel    dir  payload            beat
//  byte_in    in   byte_value[7:0]    one UTF-8 byte
//  unit_out   out  utf16_unit[15:0]   one BMP code unit, zero or one per byte
//
// One byte is taken per cycle; its unit, if any, shows on unit_out the next cycle.
// The figure is set by the single decode step between the state register and
// the output register. A held output stalls byte_in only while unit_out.ready is low.
// Reset clears the sequence state and the output valid flag.
`default_nettype none
`include "utf8_to_utf16_bmp_decoder_macros.svh"
module utf8_to_utf16_bmp_decoder (
    input  var logic       clk,
    input  var logic       rst_n,
    u8u16_byte_if.sink     byte_in,
    u8u16_unit_if.source   unit_out
);
    import u8u16_pkg::*;

    dec_state_t        state_reg;
    dec_state_t        state_next;
    dec_result_t       step_result;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [UNIT_W-1:0] out_unit_reg;
    logic              in_accept;

    // Take a byte whenever the output slot is free or being drained
    assign byte_in.ready = !out_valid_reg || unit_out.ready;
    assign in_accept     = byte_in.valid && byte_in.ready;

    u8u16_step u_step (
        .state      (state_reg),
        .byte_value (byte_in.byte_value),
        .state_next (state_next),
        .result     (step_result)
    );

    // Output valid follows the accepted byte, else drops once taken
    always_comb
    begin
        priority if (in_accept)
            out_valid_next = step_result.emit;
        else if (unit_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Sequence state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_accept && step_result.emit)
            out_unit_reg <= step_result.unit;
    end

    assign unit_out.valid      = out_valid_reg;
    assign unit_out.utf16_unit = out_unit_reg;

    // Checks
    `U8U16_ASSERT_NOW(a_stall_blocks_input, unit_out.valid && !unit_out.ready, !byte_in.ready)
    `U8U16_ASSERT_NEXT(a_nul_clears_state,
        in_accept && byte_in.byte_value == 8'h00, state_reg == '0)
    `U8U16_ASSERT_NOW(a_no_surrogate_out, unit_out.valid, unit_out.utf16_unit[15:11] != 5'b11011)
    `U8U16_ASSERT_NEXT(a_last_cont_closes,
        in_accept && byte_in.byte_value != 8'h00 && state_reg.remaining == 3'd1,
        state_reg.remaining == 3'd0 && state_reg.acc == '0)

endmodule
`default_nettype wire
